FILE: hdl/rdsr_pkg.sv
`timescale 1ns / 1ps

package rdsr_pkg;

   localparam int NUM_SETS    = 2048;
   localparam int NUM_WAYS    = 16;
   localparam int LEADER_SETS = 32;

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int WAY_W   = $clog2(NUM_WAYS);
   localparam int ADDR_W  = 16;
   localparam int RRPV_W  = 2;
   localparam int DEAD_W  = 2;
   localparam int CONF_W  = 2;
   localparam int SEL_W   = 10;
   localparam int TALLY_W = 8;
   localparam int LFSR_W  = 16;

   localparam logic [SEL_W-1:0]  SEL_INIT  = 10'd512;
   localparam logic [SEL_W-1:0]  SEL_MAX   = 10'd1023;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

   localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
   localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
   localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;

   localparam logic [DEAD_W-1:0] DEAD_FILL   = 2'd1;
   localparam logic [DEAD_W-1:0] DEAD_LIKELY = 2'd2;
   localparam logic [DEAD_W-1:0] DEAD_MAX    = 2'd3;

   localparam logic [CONF_W-1:0] CONF_MAX = 2'd3;

   localparam logic OP_VICTIM = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic [CONF_W-1:0]                conf;
      logic [ADDR_W-1:0]                prev_addr;
      logic [ADDR_W-1:0]                prev_delta;
      logic [NUM_WAYS-1:0][DEAD_W-1:0]  dead;
      logic [NUM_WAYS-1:0][RRPV_W-1:0]  rrpv;
   } row_type;

   localparam row_type ROW_INIT = '{
      conf:       '0,
      prev_addr:  '0,
      prev_delta: '0,
      dead:       '0,
      rrpv:       {NUM_WAYS{RRPV_DISTANT}}
   };

endpackage

FILE: hdl/rrip_deadblock_stream_replacement.sv
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | opcode, set_index, way, addr_low, hit
// rsp     | out       | rsp_valid, rsp_stall | victim_way, victim_valid, streaming
//
// each word first has its set row read from the metadata ram, then the row is
// modified, written back and the result register loaded
// after reset a clearing pass writes every set row, with req_stall high
// a new word is taken while a result still waits in the output register
// a stalled result holds the modify cycle of the following word

module rrip_deadblock_stream_replacement (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [10:0] req_set_index,
   input  logic [3:0]  req_way,
   input  logic [15:0] req_addr_low,
   input  logic        req_hit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_victim_way,
   output logic        rsp_victim_valid,
   output logic        rsp_streaming
);
   import rdsr_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [SET_W-1:0]   clr_ff, clr_in;

   logic               op_ff;
   logic [SET_W-1:0]   set_ff;
   logic [WAY_W-1:0]   way_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               hit_ff;

   row_type            mem [NUM_SETS];
   row_type            rd_ff;
   logic               mem_we, mem_re;
   logic [SET_W-1:0]   mem_waddr;
   row_type            mem_wdata;

   logic [SEL_W-1:0]   sel_ff, sel_in, sel_upd;
   logic [TALLY_W-1:0] tally_ff, tally_in, tally_upd;
   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in, lfsr_upd, lfsr_step;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_way_ff, out_way;
   logic               rsp_vv_ff, out_vv;
   logic               rsp_str_ff, out_str;
   logic               rsp_load;

   row_type               row_new;
   logic [NUM_WAYS-1:0]   hi_vec, lo_vec, three_vec, match_vec;
   logic [RRPV_W-1:0]     top, age;
   logic [WAY_W-1:0]      victim;
   logic [ADDR_W-1:0]     delta;
   logic                  same;
   logic [CONF_W-1:0]     conf_new;
   logic                  streaming_new;
   logic                  srrip_leader, brrip_leader, srrip_pick;
   logic [RRPV_W-1:0]     ins;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_way   = rsp_way_ff;
   assign rsp_victim_valid = rsp_vv_ff;
   assign rsp_streaming    = rsp_str_ff;

   // metadata ram, one row per set
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[req_set_index[SET_W-1:0]];
      end
   end

   // victim search and row update
   always_comb begin
      row_new   = rd_ff;
      sel_upd   = sel_ff;
      tally_upd = tally_ff;
      lfsr_upd  = lfsr_ff;
      out_way   = '0;
      out_vv    = 1'b0;
      out_str   = 1'b0;
      ins       = RRPV_LONG;

      for (int i = 0; i < NUM_WAYS; i++) begin
         hi_vec[i]    = rd_ff.rrpv[i][1];
         lo_vec[i]    = rd_ff.rrpv[i][0];
         three_vec[i] = (rd_ff.rrpv[i] == RRPV_DISTANT);
      end
      top[1] = |hi_vec;
      top[0] = top[1] ? (|three_vec) : (|lo_vec);
      age    = RRPV_DISTANT - top;
      for (int i = 0; i < NUM_WAYS; i++) begin
         match_vec[i] = (rd_ff.rrpv[i] == top);
      end
      victim = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            victim = WAY_W'(i);
         end
      end

      delta = addr_ff - rd_ff.prev_addr;
      same  = (delta == rd_ff.prev_delta) && (delta != '0);
      if (same) begin
         conf_new = (rd_ff.conf == CONF_MAX) ? rd_ff.conf : rd_ff.conf + 1'b1;
      end else begin
         conf_new = (rd_ff.conf == '0) ? rd_ff.conf : rd_ff.conf - 1'b1;
      end
      streaming_new = conf_new[1];

      srrip_leader = (set_ff < SET_W'(LEADER_SETS));
      brrip_leader = (set_ff >= SET_W'(NUM_SETS - LEADER_SETS));
      srrip_pick   = srrip_leader || (!brrip_leader && (sel_ff >= SEL_INIT));
      lfsr_step    = {1'b0, lfsr_ff[LFSR_W-1:1]} ^ (lfsr_ff[0] ? LFSR_MASK : '0);

      if (op_ff == OP_VICTIM) begin
         for (int i = 0; i < NUM_WAYS; i++) begin
            row_new.rrpv[i] = rd_ff.rrpv[i] + age;
         end
         out_way = 4'(victim);
         out_vv  = 1'b1;
      end else begin
         row_new.conf       = conf_new;
         row_new.prev_addr  = addr_ff;
         row_new.prev_delta = delta;
         out_str            = streaming_new;
         if (hit_ff) begin
            if (rd_ff.dead[way_ff] != '0) begin
               row_new.dead[way_ff] = rd_ff.dead[way_ff] - 1'b1;
            end
            row_new.rrpv[way_ff] = RRPV_NEAR;
            tally_upd = tally_ff + 1'b1;
            if (tally_upd == '0) begin
               for (int k = 0; k < NUM_WAYS; k++) begin
                  if (row_new.dead[k] != DEAD_MAX) begin
                     row_new.dead[k] = row_new.dead[k] + 1'b1;
                  end
               end
            end
            if (srrip_leader) begin
               if (sel_ff != SEL_MAX) begin
                  sel_upd = sel_ff + 1'b1;
               end
            end else if (brrip_leader) begin
               if (sel_ff != '0) begin
                  sel_upd = sel_ff - 1'b1;
               end
            end
         end else begin
            if (!srrip_pick) begin
               lfsr_upd = lfsr_step;
               ins = (lfsr_step[4:0] == '0) ? RRPV_LONG : RRPV_DISTANT;
            end
            if (streaming_new) begin
               row_new.rrpv[way_ff] = RRPV_DISTANT;
               row_new.dead[way_ff] = DEAD_LIKELY;
            end else begin
               if (rd_ff.dead[way_ff] >= DEAD_LIKELY) begin
                  ins = RRPV_DISTANT;
               end
               row_new.rrpv[way_ff] = ins;
               row_new.dead[way_ff] = DEAD_FILL;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = set_ff;
      mem_wdata = row_new;
      sel_in    = sel_ff;
      tally_in  = tally_ff;
      lfsr_in   = lfsr_ff;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = ROW_INIT;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mem_re   = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               mem_we   = 1'b1;
               rsp_load = 1'b1;
               sel_in   = sel_upd;
               tally_in = tally_upd;
               lfsr_in  = lfsr_upd;
               state_in = ST_IDLE;
            end
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sel_ff       <= SEL_INIT;
         tally_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sel_ff       <= sel_in;
         tally_ff     <= tally_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         op_ff   <= req_opcode;
         set_ff  <= req_set_index[SET_W-1:0];
         way_ff  <= req_way[WAY_W-1:0];
         addr_ff <= req_addr_low;
         hit_ff  <= req_hit;
      end
      if (rsp_load) begin
         rsp_way_ff <= out_way;
         rsp_vv_ff  <= out_vv;
         rsp_str_ff <= out_str;
      end
   end

`ifndef SYNTHESIS
   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted word did not enter the modify cycle");

   a_no_reclear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass restarted without reset");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_EXEC) || (state_ff == ST_CLEAR)))
      else $error("metadata write outside modify or clear");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_vv_ff && rsp_str_ff))
      else $error("result marks both victim and streaming");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rdsr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic              opcode;
      logic [SET_W-1:0]  set_index;
      logic [WAY_W-1:0]  way;
      logic [ADDR_W-1:0] addr_low;
      logic              hit;
      logic              pinned;
      logic [WAY_W-1:0]  pin_way;
      logic              pin_valid;
      logic              pin_streaming;
   } access_word_type;

   typedef struct packed {
      logic [WAY_W-1:0] victim_way;
      logic             victim_valid;
      logic             streaming;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   access_word_type cur_word = '0;

   logic             req_stall;
   logic             req_opcode;
   logic [10:0]      req_set_index;
   logic [3:0]       req_way;
   logic [15:0]      req_addr_low;
   logic             req_hit;
   logic             rsp_valid;
   logic [3:0]       rsp_victim_way;
   logic             rsp_victim_valid;
   logic             rsp_streaming;

   assign req_opcode    = cur_word.opcode;
   assign req_set_index = cur_word.set_index;
   assign req_way       = cur_word.way;
   assign req_addr_low  = cur_word.addr_low;
   assign req_hit       = cur_word.hit;

   rrip_deadblock_stream_replacement dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_set_index    (req_set_index),
      .req_way          (req_way),
      .req_addr_low     (req_addr_low),
      .req_hit          (req_hit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_victim_way   (rsp_victim_way),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_streaming    (rsp_streaming)
   );

   always #5 clock = ~clock;

   // predicted replacement state
   logic [RRPV_W-1:0] rrpv_mem      [NUM_SETS][NUM_WAYS];
   logic [DEAD_W-1:0] dead_mem      [NUM_SETS][NUM_WAYS];
   logic [CONF_W-1:0] conf_mem      [NUM_SETS];
   logic [ADDR_W-1:0] prev_addr_mem [NUM_SETS];
   logic [ADDR_W-1:0] prev_delta_mem[NUM_SETS];
   logic [SEL_W-1:0]  duel_selector;
   logic [TALLY_W-1:0] model_hits;
   logic [LFSR_W-1:0] insert_lfsr;

   outcome_type pending_outcomes [$];
   int words_taken = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int brrip_share = 20;
   int srrip_share = 20;
   int hold_len = 0;
   int hold_serial = 0;
   int hold_seen = 0;
   int hold_left = 0;

   task automatic clear_model();
      int s;
      int k;
      for (s = 0; s < NUM_SETS; s++) begin
         for (k = 0; k < NUM_WAYS; k++) begin
            rrpv_mem[s][k] = RRPV_DISTANT;
            dead_mem[s][k] = '0;
         end
         conf_mem[s] = '0;
         prev_addr_mem[s] = '0;
         prev_delta_mem[s] = '0;
      end
      duel_selector = SEL_INIT;
      model_hits = '0;
      insert_lfsr = LFSR_SEED;
   endtask

   function automatic outcome_type rrip_access(access_word_type w);
      outcome_type o;
      int s;
      int wy;
      int k;
      logic [RRPV_W-1:0] top;
      logic [RRPV_W-1:0] ins;
      logic [ADDR_W-1:0] delta;
      logic srrip_leader;
      logic brrip_leader;
      logic srrip_pick;
      s = w.set_index;
      wy = w.way;
      o = '0;
      srrip_leader = (s < LEADER_SETS);
      brrip_leader = (s >= NUM_SETS - LEADER_SETS);
      if (w.opcode == OP_VICTIM) begin
         top = '0;
         for (k = 0; k < NUM_WAYS; k++)
            if (rrpv_mem[s][k] > top) top = rrpv_mem[s][k];
         if (top < RRPV_DISTANT)
            for (k = 0; k < NUM_WAYS; k++)
               rrpv_mem[s][k] = rrpv_mem[s][k] + (RRPV_DISTANT - top);
         for (k = NUM_WAYS - 1; k >= 0; k--)
            if (rrpv_mem[s][k] == RRPV_DISTANT) o.victim_way = WAY_W'(k);
         o.victim_valid = 1'b1;
      end else begin
         // stream detector
         delta = w.addr_low - prev_addr_mem[s];
         if (delta == prev_delta_mem[s] && delta != '0) begin
            if (conf_mem[s] < CONF_MAX) conf_mem[s]++;
         end else begin
            if (conf_mem[s] > 0) conf_mem[s]--;
         end
         prev_delta_mem[s] = delta;
         prev_addr_mem[s] = w.addr_low;
         o.streaming = (conf_mem[s] >= 2);
         if (w.hit) begin
            if (dead_mem[s][wy] > 0) dead_mem[s][wy]--;
            rrpv_mem[s][wy] = RRPV_NEAR;
            model_hits++;
            if (model_hits == '0)
               for (k = 0; k < NUM_WAYS; k++)
                  if (dead_mem[s][k] < DEAD_MAX) dead_mem[s][k]++;
            if (srrip_leader) begin
               if (duel_selector < SEL_MAX) duel_selector++;
            end else if (brrip_leader) begin
               if (duel_selector > 0) duel_selector--;
            end
         end else begin
            if (srrip_leader) srrip_pick = 1'b1;
            else if (brrip_leader) srrip_pick = 1'b0;
            else srrip_pick = (duel_selector >= SEL_INIT);
            ins = RRPV_LONG;
            if (!srrip_pick) begin
               insert_lfsr = insert_lfsr[0] ? ((insert_lfsr >> 1) ^ LFSR_MASK)
                                            : (insert_lfsr >> 1);
               ins = (insert_lfsr[4:0] == 5'd0) ? RRPV_LONG : RRPV_DISTANT;
            end
            if (o.streaming) begin
               rrpv_mem[s][wy] = RRPV_DISTANT;
               dead_mem[s][wy] = DEAD_LIKELY;
            end else begin
               if (dead_mem[s][wy] >= DEAD_LIKELY) ins = RRPV_DISTANT;
               rrpv_mem[s][wy] = ins;
               dead_mem[s][wy] = DEAD_FILL;
            end
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      outcome_type predicted;
      outcome_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = rrip_access(cur_word);
            want = predicted;
            if (cur_word.pinned) begin
               want.victim_way = cur_word.pin_way;
               want.victim_valid = cur_word.pin_valid;
               want.streaming = cur_word.pin_streaming;
            end
            pending_outcomes.push_back(want);
            words_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unrequested word", 1, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_victim_way !== want.victim_way)
                  report_mismatch("victim_way", rsp_victim_way, want.victim_way);
               if (rsp_victim_valid !== want.victim_valid)
                  report_mismatch("victim_valid", rsp_victim_valid, want.victim_valid);
               if (rsp_streaming !== want.streaming)
                  report_mismatch("streaming", rsp_streaming, want.streaming);
            end
         end
      end
   end

   // receiver side: random stall plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("rrip_deadblock_stream_replacement regression: fail");
      $finish;
   end

   task automatic send_word(input access_word_type w);
      int n;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      cur_word <= w;
      n = words_taken;
      do @(negedge clock); while (words_taken == n);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
   endtask

   function automatic logic [SET_W-1:0] pick_set();
      int r;
      r = $urandom_range(99);
      if (r < 10) return SET_W'($urandom);
      if (r < 10 + brrip_share) begin
         case ($urandom_range(2))
            0: return 11'd2016;
            1: return 11'd2040;
            default: return 11'd2047;
         endcase
      end
      if (r < 10 + brrip_share + srrip_share) begin
         case ($urandom_range(2))
            0: return 11'd0;
            1: return 11'd1;
            default: return 11'd31;
         endcase
      end
      case ($urandom_range(4))
         0: return 11'd32;
         1: return 11'd1000;
         2: return 11'd1023;
         3: return 11'd1024;
         default: return 11'd2015;
      endcase
   endfunction

   // mostly strided access runs on one set, the rest unrelated words
   task automatic run_random(input int count);
      int sent;
      int run_len;
      int k;
      logic [SET_W-1:0] run_set;
      logic [ADDR_W-1:0] run_addr;
      logic [ADDR_W-1:0] run_stride;
      access_word_type w;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 70) begin
            run_set = pick_set();
            run_addr = ADDR_W'($urandom);
            run_stride = ($urandom_range(1) == 1) ? ADDR_W'($urandom_range(1, 8))
                                                  : ADDR_W'($urandom);
            run_len = $urandom_range(3, 10);
            for (k = 0; k < run_len && sent < count; k++) begin
               w = '0;
               w.set_index = run_set;
               w.way = WAY_W'($urandom);
               w.addr_low = ADDR_W'($urandom);
               w.hit = 1'($urandom);
               if ($urandom_range(99) < 15) begin
                  w.opcode = OP_VICTIM;
               end else begin
                  w.opcode = OP_UPDATE;
                  w.hit = ($urandom_range(99) < 85);
                  if ($urandom_range(99) < 8) run_addr = ADDR_W'($urandom);
                  w.addr_low = run_addr;
                  run_addr = run_addr + run_stride;
               end
               send_word(w);
               sent++;
            end
         end else begin
            w = '0;
            w.opcode = ($urandom_range(1) == 1) ? OP_UPDATE : OP_VICTIM;
            w.set_index = pick_set();
            w.way = WAY_W'($urandom);
            w.addr_low = ADDR_W'($urandom);
            w.hit = 1'($urandom);
            send_word(w);
            sent++;
         end
      end
   endtask

   function automatic access_word_type plan_row(logic op, logic [SET_W-1:0] set_i,
                                                logic [WAY_W-1:0] wy,
                                                logic [ADDR_W-1:0] addr,
                                                logic h, logic pin, logic [WAY_W-1:0] pw,
                                                logic pv, logic ps);
      access_word_type w;
      w = '{op, set_i, wy, addr, h, pin, pw, pv, ps};
      return w;
   endfunction

   initial begin
      access_word_type directed_plan [$];
      int i;
      clear_model();
      directed_plan = '{
         plan_row(OP_VICTIM, 11'd0,    4'd0,  16'h0000, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0),
         plan_row(OP_VICTIM, 11'd2047, 4'd15, 16'hFFFF, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0),
         plan_row(OP_UPDATE, 11'd5,    4'd15, 16'hFFFF, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0),
         plan_row(OP_VICTIM, 11'd5,    4'd0,  16'h0000, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0),
         plan_row(OP_UPDATE, 11'd5,    4'd0,  16'hFFFE, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd5,    4'd1,  16'hFFFD, 1'b0, 1'b1, 4'd0, 1'b0, 1'b1),
         plan_row(OP_UPDATE, 11'd5,    4'd2,  16'hFFFC, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd5,    4'd3,  16'hFFFC, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_VICTIM, 11'd5,    4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd5,    4'd1,  16'h1234, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_VICTIM, 11'd5,    4'd7,  16'h0000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd2047, 4'd0,  16'h0010, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd2040, 4'd7,  16'h8000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd1000, 4'd4,  16'h5555, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_VICTIM, 11'd1000, 4'd15, 16'hFFFF, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd0,    4'd0,  16'h0000, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd2047, 4'd15, 16'hAAAA, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd31,   4'd8,  16'h0001, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd2016, 4'd9,  16'hFFFF, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_VICTIM, 11'd2047, 4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0),
         plan_row(OP_UPDATE, 11'd32,   4'd15, 16'h7FFF, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_plan.size(); i++)
         send_word(directed_plan[i]);
      wait_drained();

      // no idling, brrip leaders hit more so followers lean to brrip
      brrip_share = 40;
      srrip_share = 10;
      run_random(100);
      wait_drained();

      sender_idle_pct = 86;
      brrip_share = 20;
      srrip_share = 20;
      run_random(100);
      wait_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 86;
      brrip_share = 10;
      srrip_share = 40;
      run_random(100);
      wait_drained();

      sender_idle_pct = 7;
      receiver_stall_pct = 7;
      brrip_share = 20;
      srrip_share = 20;
      run_random(100);

      // long receiver hold-off while words keep coming
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_len <= 400;
      hold_serial <= hold_serial + 1;
      run_random(24);
      wait_drained();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("rrip_deadblock_stream_replacement regression: pass");
      else
         $display("rrip_deadblock_stream_replacement regression: fail");
      $finish;
   end

endmodule
